/* rtl/sfir_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfir_pkg: shared types and constants of the stereo FIR filter
// Field widths, function codes and the control bundle passed from the tap
// sequencer to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package sfir_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 16;
	localparam int COEF_IDX_W = 7;
	localparam int TAP_CNT_W  = 8;
	localparam int PROD_W     = SAMPLE_W + COEF_W;
	localparam int FRAC_BITS  = 15;

	// item function codes
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_FRAME = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;

	// sequencer to MAC control bundle
	typedef struct packed {
		logic acc_clr;  // start of a new frame: clear both accumulators
		logic tap_vld;  // read data of one tap is present this cycle
		logic hist_ok;  // history slot holds a written sample
	} mac_ctl_t;

endpackage
`default_nettype wire

/* rtl/sfir_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfir_if: stream channels of the stereo FIR filter
// Input channel carries coefficient loads and stereo frames, output channel
// carries filtered stereo samples. Valid/ready handshake on both.
// ----------------------------------------------------------------------------
interface sfir_in_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  func;
	logic [sfir_pkg::COEF_IDX_W-1:0]       coef_index;
	logic signed [sfir_pkg::COEF_W-1:0]    coef_value;
	logic signed [sfir_pkg::SAMPLE_W-1:0]  left_in;
	logic signed [sfir_pkg::SAMPLE_W-1:0]  right_in;

	modport source (output valid, func, coef_index, coef_value, left_in, right_in,
		input ready);
	modport sink (input valid, func, coef_index, coef_value, left_in, right_in,
		output ready);
endinterface

interface sfir_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [sfir_pkg::SAMPLE_W-1:0]  left_out;
	logic signed [sfir_pkg::SAMPLE_W-1:0]  right_out;

	modport source (output valid, left_out, right_out, input ready);
	modport sink (input valid, left_out, right_out, output ready);
endinterface
`default_nettype wire

/* rtl/stereo_fir_filter_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_fir_filter_top: stereo direct-form FIR filter
// A load item writes one Q1.15 coefficient; a frame item pushes a left and
// right sample into the delay line and returns one filtered stereo sample.
// ----------------------------------------------------------------------------
// A stereo frame occupies the block while it walks the taps in use, where a
// tap_count above MAX_TAPS counts as MAX_TAPS; a tap count of zero goes
// straight to the drain. One shared dual-lane multiply-accumulate unit
// processes one tap of both channels per cycle, fed from the coefficient
// RAM and the stereo delay-line RAM, plus the RAM read, product and drain
// stages. Loads are taken while a result still waits in the output register;
// a new frame can finish only once that register is free. The delay line
// reads as zero until written, without a clearing pass; coefficients must be
// loaded before they are used. The user must write tap_count only while the
// block is idle; the block itself does not enforce it.
module stereo_fir_filter_top #(
	parameter int MAX_TAPS = 128
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	sfir_in_if.sink                              in_ch,
	sfir_out_if.source                           out_ch,
	input  wire logic                            cfg_we,
	input  wire logic [sfir_pkg::TAP_CNT_W-1:0]  cfg_wdata
);

	logic [sfir_pkg::TAP_CNT_W-1:0]  tap_count_q;
	logic                            out_vld_q;
	sfir_pkg::sample_t               left_q;
	sfir_pkg::sample_t               right_q;

	sfir_pkg::mac_ctl_t  mac_ctl;
	sfir_pkg::coef_t     coef_s1;
	sfir_pkg::sample_t   left_s1;
	sfir_pkg::sample_t   right_s1;
	sfir_pkg::sample_t   left_res;
	sfir_pkg::sample_t   right_res;
	logic                mac_busy;
	logic                out_free;
	logic                out_load;

	// tap count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= sfir_pkg::TAP_CNT_W'(1);
		end else if (cfg_we) begin
			tap_count_q <= cfg_wdata;
		end
	end

	sfir_ctrl #(
		.MAX_TAPS (MAX_TAPS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.func       (in_ch.func),
		.coef_index (in_ch.coef_index),
		.coef_value (in_ch.coef_value),
		.left_in    (in_ch.left_in),
		.right_in   (in_ch.right_in),
		.tap_count  (tap_count_q),
		.mac_ctl    (mac_ctl),
		.coef_s1    (coef_s1),
		.left_s1    (left_s1),
		.right_s1   (right_s1),
		.mac_busy   (mac_busy),
		.out_free   (out_free),
		.out_load   (out_load)
	);

	sfir_mac #(
		.MAX_TAPS (MAX_TAPS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.mac_ctl   (mac_ctl),
		.coef_s1   (coef_s1),
		.left_s1   (left_s1),
		.right_s1  (right_s1),
		.mac_busy  (mac_busy),
		.left_res  (left_res),
		.right_res (right_res)
	);

	// output register: free when empty or when its transfer completes
	assign out_free = ~out_vld_q | out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// hold the result until it is taken
	always_ff @(posedge clk) begin
		if (out_load) begin
			left_q  <= left_res;
			right_q <= right_res;
		end
	end

	assign out_ch.valid     = out_vld_q;
	assign out_ch.left_out  = left_q;
	assign out_ch.right_out = right_q;

endmodule
`default_nettype wire

/* rtl/sfir_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfir_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sfir_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/sfir_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfir_ctrl: tap sequencer of the stereo FIR filter
// Holds the coefficient table and the stereo delay line, pushes frames,
// walks the taps one per cycle and hands read data to the MAC unit.
// ----------------------------------------------------------------------------
module sfir_ctrl #(
	parameter int MAX_TAPS = 128
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input channel
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                func,
	input  wire logic [sfir_pkg::COEF_IDX_W-1:0]     coef_index,
	input  wire sfir_pkg::coef_t                     coef_value,
	input  wire sfir_pkg::sample_t                   left_in,
	input  wire sfir_pkg::sample_t                   right_in,
	// configuration
	input  wire logic [sfir_pkg::TAP_CNT_W-1:0]      tap_count,
	// MAC side
	output sfir_pkg::mac_ctl_t                       mac_ctl,
	output sfir_pkg::coef_t                          coef_s1,
	output sfir_pkg::sample_t                        left_s1,
	output sfir_pkg::sample_t                        right_s1,
	input  wire logic                                mac_busy,
	// result side
	input  wire logic                                out_free,
	output logic                                     out_load
);

	localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CW = $clog2(MAX_TAPS + 1);
	localparam int HW = 2 * sfir_pkg::SAMPLE_W;
	localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_TAPS - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

	state_t         state_q;
	logic [AW-1:0]  newest_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  fill_q;
	logic [CW-1:0]  k_q;
	logic [CW-1:0]  taps_q;
	logic           tap_vld_s1;
	logic           hist_ok_s1;

	logic [AW-1:0]  next_pos;
	logic [CW-1:0]  taps_eff;
	logic           accept;
	logic           frame_acc;
	logic           issue;
	logic           coef_we;
	logic [HW-1:0]  hist_rdata;

	// handshake and decode
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid & in_ready;
	assign frame_acc = accept & (func == sfir_pkg::FUNC_FRAME);
	assign coef_we   = accept & (func == sfir_pkg::FUNC_LOAD)
		& (32'(coef_index) < MAX_TAPS);
	assign issue     = (state_q == ST_RUN);

	// advance the ring position with wrap
	assign next_pos = (newest_q == LAST_SLOT) ? '0 : newest_q + 1'b1;

	// clamp the tap count to the table size
	assign taps_eff = (32'(tap_count) > MAX_TAPS) ? CW'(MAX_TAPS) : CW'(tap_count);

	sfir_ram #(
		.WIDTH (sfir_pkg::COEF_W),
		.DEPTH (MAX_TAPS)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (AW'(coef_index)),
		.wdata (coef_value),
		.raddr (k_q[AW-1:0]),
		.rdata (coef_s1)
	);

	sfir_ram #(
		.WIDTH (HW),
		.DEPTH (MAX_TAPS)
	) u_hist_ram (
		.clk   (clk),
		.we    (frame_acc),
		.waddr (next_pos),
		.wdata ({left_in, right_in}),
		.raddr (rd_ptr_q),
		.rdata (hist_rdata)
	);

	assign left_s1  = hist_rdata[HW-1:sfir_pkg::SAMPLE_W];
	assign right_s1 = hist_rdata[sfir_pkg::SAMPLE_W-1:0];

	// drain done once the last tap has left the MAC pipeline and the output register is free
	assign out_load = (state_q == ST_DRAIN) & ~tap_vld_s1 & ~mac_busy & out_free;

	assign mac_ctl = '{acc_clr: frame_acc, tap_vld: tap_vld_s1, hist_ok: hist_ok_s1};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			newest_q   <= '0;
			rd_ptr_q   <= '0;
			fill_q     <= '0;
			k_q        <= '0;
			taps_q     <= '0;
			tap_vld_s1 <= 1'b0;
			hist_ok_s1 <= 1'b0;
		end else begin
			tap_vld_s1 <= issue;
			hist_ok_s1 <= (k_q < fill_q);
			unique case (state_q)
				ST_IDLE: begin
					if (frame_acc) begin
						newest_q <= next_pos;
						rd_ptr_q <= next_pos;
						k_q      <= '0;
						taps_q   <= taps_eff;
						if (fill_q != CW'(MAX_TAPS)) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= (taps_eff == '0) ? ST_DRAIN : ST_RUN;
					end
				end
				ST_RUN: begin
					k_q      <= k_q + 1'b1;
					rd_ptr_q <= (rd_ptr_q == '0) ? LAST_SLOT : rd_ptr_q - 1'b1;
					if ((k_q + CW'(1)) == taps_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/sfir_mac.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfir_mac: dual-lane multiply-accumulate unit
// One registered 16x16 product per channel per cycle, wide accumulators,
// and the truncate-toward-zero and saturate step of the final sums.
// ----------------------------------------------------------------------------
module sfir_mac #(
	parameter int MAX_TAPS = 128
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sfir_pkg::mac_ctl_t  mac_ctl,
	input  wire sfir_pkg::coef_t     coef_s1,
	input  wire sfir_pkg::sample_t   left_s1,
	input  wire sfir_pkg::sample_t   right_s1,
	output logic                     mac_busy,
	output sfir_pkg::sample_t        left_res,
	output sfir_pkg::sample_t        right_res
);

	localparam int ACC_W = sfir_pkg::PROD_W + $clog2(MAX_TAPS + 1);
	localparam logic signed [ACC_W-1:0] BIAS    = ACC_W'((1 << sfir_pkg::FRAC_BITS) - 1);
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

	logic                                  v_s2;
	logic signed [sfir_pkg::PROD_W-1:0]    prod_l_s2;
	logic signed [sfir_pkg::PROD_W-1:0]    prod_r_s2;
	logic signed [ACC_W-1:0]               acc_l_q;
	logic signed [ACC_W-1:0]               acc_r_q;
	sfir_pkg::sample_t                     hl;
	sfir_pkg::sample_t                     hr;

	// scale a Q25.15 sum to an integer toward zero, then saturate
	function automatic sfir_pkg::sample_t finish(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] biased;
		logic signed [ACC_W-1:0] q;
		biased = acc[ACC_W-1] ? acc + BIAS : acc;
		q      = biased >>> sfir_pkg::FRAC_BITS;
		if (q > SAT_MAX) begin
			finish = sfir_pkg::SAMPLE_W'(SAT_MAX);
		end else if (q < SAT_MIN) begin
			finish = sfir_pkg::SAMPLE_W'(SAT_MIN);
		end else begin
			finish = q[sfir_pkg::SAMPLE_W-1:0];
		end
	endfunction

	// slots not yet written since reset read as zero
	assign hl = mac_ctl.hist_ok ? left_s1 : '0;
	assign hr = mac_ctl.hist_ok ? right_s1 : '0;

	assign mac_busy = v_s2;

	// product stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= mac_ctl.tap_vld;
		end
	end

	// multiply and accumulate
	always_ff @(posedge clk) begin
		prod_l_s2 <= coef_s1 * hl;
		prod_r_s2 <= coef_s1 * hr;
		if (mac_ctl.acc_clr) begin
			acc_l_q <= '0;
			acc_r_q <= '0;
		end else if (v_s2) begin
			acc_l_q <= acc_l_q + ACC_W'(prod_l_s2);
			acc_r_q <= acc_r_q + ACC_W'(prod_r_s2);
		end
	end

	assign left_res  = finish(acc_l_q);
	assign right_res = finish(acc_r_q);

endmodule
`default_nettype wire
